### rtl/core/lcut_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lcut_pkg;

  // Default grid bounds
  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  // Field and internal widths
  localparam int SIZE_W     = 7;   // num_rows / num_cols registers
  localparam int IDX_W      = 12;  // cell_index
  localparam int REQ_W      = 2;   // req_type
  localparam int LIN_W      = 14;  // linear index up to 127 * 127 cells
  localparam int COUNT_W    = 4;   // neighbour count, 0..8
  localparam int STEP_W     = 4;   // neighbour read step, 0..8
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W  = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 1'b1;

  // Request kinds
  localparam logic [REQ_W-1:0] REQ_WRITE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_COMMIT = 2'd3;

  // B3/S23 rule counts
  localparam logic [COUNT_W-1:0] SURVIVE_LO  = 4'd2;
  localparam logic [COUNT_W-1:0] BIRTH_COUNT = 4'd3;

  // Neighbour walk: nine reads in row-major order, centre in the middle
  localparam logic [STEP_W-1:0] CENTRE_STEP = 4'd4;
  localparam logic [STEP_W-1:0] LAST_STEP   = 4'd8;

  localparam logic [1:0] SEL_LO  = 2'd0;  // row above / column left
  localparam logic [1:0] SEL_MID = 2'd1;
  localparam logic [1:0] SEL_HI  = 2'd2;  // row below / column right

  function automatic logic [1:0] nbr_row(input logic [STEP_W-1:0] step);
    logic [1:0] sel;
    case (step)
      4'd0, 4'd1, 4'd2: sel = SEL_LO;
      4'd3, 4'd4, 4'd5: sel = SEL_MID;
      default:          sel = SEL_HI;
    endcase
    return sel;
  endfunction

  function automatic logic [1:0] nbr_col(input logic [STEP_W-1:0] step);
    logic [1:0] sel;
    case (step)
      4'd0, 4'd3, 4'd6: sel = SEL_LO;
      4'd1, 4'd4, 4'd7: sel = SEL_MID;
      default:          sel = SEL_HI;
    endcase
    return sel;
  endfunction

  // Controller to datapath
  typedef struct packed {
    logic clear;      // clearing pass write
    logic load;       // take the input item
    logic div_step;   // one bit of index / num_cols
    logic geo;        // register neighbour row bases and columns
    logic nbr_issue;  // one neighbour read
    logic rd_issue;   // read of the addressed cell
    logic finish;     // apply effects and load the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             oor;
    logic             div_last;
    logic             step_last;
    logic             clr_last;
    logic             out_free;
  } status_t;

endpackage

`default_nettype wire

### rtl/core/lcut_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lcut_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/core/lcut_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lcut_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire lcut_pkg::status_t st,
  output lcut_pkg::cmd_t         cmd
);

  import lcut_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_GEO   = 4'd4;
  localparam logic [3:0] S_NBR   = 4'd5;
  localparam logic [3:0] S_DRAIN = 4'd6;
  localparam logic [3:0] S_RD    = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Sequencing of one item
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (st.oor || st.req == REQ_WRITE || st.req == REQ_COMMIT) begin
          state_nxt = S_FIN;
        end else if (st.req == REQ_READ) begin
          state_nxt = S_RD;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) state_nxt = S_GEO;
      end
      S_GEO: begin
        cmd.geo   = 1'b1;
        state_nxt = S_NBR;
      end
      S_NBR: begin
        cmd.nbr_issue = 1'b1;
        if (st.step_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        state_nxt = S_FIN;
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_FIN;
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // An accepted item always goes to dispatch next
  a_accept_disp: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_DISP))
    else $error("accepted item did not reach dispatch");

  // The clearing pass runs once after reset only
  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_CLEAR) |=> (state_r != S_CLEAR))
    else $error("clearing pass re-entered");

endmodule

`default_nettype wire

### rtl/core/lcut_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module lcut_dp #(
  parameter int MAX_ROWS = lcut_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = lcut_pkg::DEF_MAX_COLS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [lcut_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [lcut_pkg::SIZE_W-1:0]          cfg_wdata,
  input  wire logic [lcut_pkg::IN_DATA_W-1:0]       in_tdata,
  input  wire logic [lcut_pkg::REQ_W-1:0]           in_tuser,
  input  wire lcut_pkg::cmd_t                       cmd,
  output lcut_pkg::status_t                         st,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic      [lcut_pkg::OUT_DATA_W-1:0]      out_tdata
);

  import lcut_pkg::*;

  localparam int Depth   = MAX_ROWS * MAX_COLS;
  localparam int AddrW   = $clog2(Depth);
  localparam int SizeMax = (1 << SIZE_W) - 1;
  localparam int RowLimI = (MAX_ROWS > SizeMax) ? SizeMax : MAX_ROWS;
  localparam int ColLimI = (MAX_COLS > SizeMax) ? SizeMax : MAX_COLS;
  localparam logic [SIZE_W-1:0] RowLim = SIZE_W'(RowLimI);
  localparam logic [SIZE_W-1:0] ColLim = SIZE_W'(ColLimI);

  // Configuration
  logic [SIZE_W-1:0] rows_r, cols_r;
  logic [SIZE_W-1:0] eff_rows, eff_cols;
  logic [LIN_W-1:0]  total, cols_l;

  // Item
  logic [REQ_W-1:0]  type_r;
  logic [IDX_W-1:0]  idx_r;
  logic              val_r;
  logic              oor;
  logic              sel_r;

  // Divider
  logic [SIZE_W-1:0] rem_r, rem_nxt;
  logic [IDX_W-1:0]  quo_r;
  logic [3:0]        dcnt_r;
  logic [SIZE_W:0]   trial;
  logic              ge;

  // Geometry
  logic [LIN_W-1:0]  base, up_nxt, dn_nxt;
  logic [LIN_W-1:0]  geo_up_r, geo_mid_r, geo_dn_r;
  logic [SIZE_W-1:0] col_q, row_q, lt_nxt, rt_nxt;
  logic [SIZE_W-1:0] col_lt_r, col_mid_r, col_rt_r;

  // Neighbour walk
  logic [STEP_W-1:0]  step_r, step_d_r;
  logic               issue_d_r;
  logic [LIN_W-1:0]   row_base, nbr_lin;
  logic [SIZE_W-1:0]  col_pick;
  logic [COUNT_W-1:0] count_r;
  logic               centre_r;
  logic               live;

  // Clearing pass
  logic [AddrW-1:0] clr_r;

  // Memory ports
  logic [AddrW-1:0] cur_addr, nxt_addr, a_addr, b_addr;
  logic             cur_we, cur_wd, cur_re, nxt_we, nxt_wd;
  logic             a_we, a_wd, a_re, b_we, b_wd, b_re;
  logic             a_rd, b_rd, cur_rd;

  // Result register
  logic             out_valid_r, out_state_r, res;

  // Size clamping and grid extent
  assign eff_rows = (rows_r == '0) ? SIZE_W'(1) : ((rows_r > RowLim) ? RowLim : rows_r);
  assign eff_cols = (cols_r == '0) ? SIZE_W'(1) : ((cols_r > ColLim) ? ColLim : cols_r);
  assign total    = LIN_W'(eff_rows) * LIN_W'(eff_cols);
  assign cols_l   = LIN_W'(eff_cols);
  assign oor      = LIN_W'(idx_r) >= total;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= SIZE_W'(DEF_MAX_ROWS);
      cols_r <= SIZE_W'(DEF_MAX_COLS);
    end else if (cfg_we) begin
      if (cfg_index == CFG_NUM_ROWS) rows_r <= cfg_wdata;
      if (cfg_index == CFG_NUM_COLS) cols_r <= cfg_wdata;
    end
  end

  // Restoring divider: one quotient bit a cycle, MSB first
  assign trial   = {rem_r, quo_r[IDX_W-1]};
  assign ge      = trial >= {1'b0, eff_cols};
  assign rem_nxt = ge ? SIZE_W'(trial - {1'b0, eff_cols}) : trial[SIZE_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      type_r <= in_tuser;
      idx_r  <= in_tdata[IDX_W-1:0];
      val_r  <= in_tdata[IDX_W];
      quo_r  <= in_tdata[IDX_W-1:0];
      rem_r  <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      quo_r  <= {quo_r[IDX_W-2:0], ge};
      rem_r  <= rem_nxt;
      dcnt_r <= dcnt_r + 4'd1;
    end
  end

  // Row bases and columns of the 3x3 window, wrapped round the torus
  assign row_q  = quo_r[SIZE_W-1:0];
  assign col_q  = rem_r;
  assign base   = LIN_W'(idx_r) - LIN_W'(col_q);
  assign up_nxt = (row_q == '0) ? (total - cols_l) : (base - cols_l);
  assign dn_nxt = (row_q == eff_rows - SIZE_W'(1)) ? '0 : (base + cols_l);
  assign lt_nxt = (col_q == '0) ? (eff_cols - SIZE_W'(1)) : (col_q - SIZE_W'(1));
  assign rt_nxt = (col_q == eff_cols - SIZE_W'(1)) ? '0 : (col_q + SIZE_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.geo) begin
      geo_up_r  <= up_nxt;
      geo_mid_r <= base;
      geo_dn_r  <= dn_nxt;
      col_lt_r  <= lt_nxt;
      col_mid_r <= col_q;
      col_rt_r  <= rt_nxt;
    end
  end

  // Neighbour address for the current step
  always_comb begin
    case (nbr_row(step_r))
      SEL_LO:  row_base = geo_up_r;
      SEL_MID: row_base = geo_mid_r;
      default: row_base = geo_dn_r;
    endcase
    case (nbr_col(step_r))
      SEL_LO:  col_pick = col_lt_r;
      SEL_MID: col_pick = col_mid_r;
      default: col_pick = col_rt_r;
    endcase
  end

  assign nbr_lin = row_base + LIN_W'(col_pick);

  // Step counter, and accumulation in the cycle after each read is issued
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_d_r <= 1'b0;
      count_r   <= '0;
    end else begin
      issue_d_r <= cmd.nbr_issue;
      if (cmd.load) begin
        count_r <= '0;
      end else if (issue_d_r && step_d_r != CENTRE_STEP) begin
        count_r <= count_r + COUNT_W'(cur_rd);
      end
    end
  end

  always_ff @(posedge clk) begin
    step_d_r <= step_r;
    if (cmd.geo) begin
      step_r <= '0;
    end else if (cmd.nbr_issue) begin
      step_r <= step_r + STEP_W'(1);
    end
    if (issue_d_r && step_d_r == CENTRE_STEP) begin
      centre_r <= cur_rd;
    end
  end

  // B3/S23
  assign live = centre_r ? (count_r == SURVIVE_LO || count_r == BIRTH_COUNT)
                         : (count_r == BIRTH_COUNT);

  // Clearing pass over bank a
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clear) begin
      clr_r <= clr_r + AddrW'(1);
    end
  end

  // Current and next bank accesses
  always_comb begin
    cur_addr = AddrW'(idx_r);
    cur_we   = 1'b0;
    cur_wd   = val_r;
    cur_re   = 1'b0;
    if (cmd.clear) begin
      cur_addr = clr_r;
      cur_we   = 1'b1;
      cur_wd   = 1'b0;
    end else if (cmd.nbr_issue) begin
      cur_addr = AddrW'(nbr_lin);
      cur_re   = 1'b1;
    end else if (cmd.rd_issue) begin
      cur_re   = 1'b1;
    end else if (cmd.finish && type_r == REQ_WRITE && !oor) begin
      cur_we   = 1'b1;
    end
  end

  assign nxt_addr = AddrW'(idx_r);
  assign nxt_we   = cmd.finish && type_r == REQ_UPDATE && !oor;
  assign nxt_wd   = live;

  assign a_addr = sel_r ? nxt_addr : cur_addr;
  assign a_we   = sel_r ? nxt_we   : cur_we;
  assign a_wd   = sel_r ? nxt_wd   : cur_wd;
  assign a_re   = sel_r ? 1'b0     : cur_re;
  assign b_addr = sel_r ? cur_addr : nxt_addr;
  assign b_we   = sel_r ? cur_we   : nxt_we;
  assign b_wd   = sel_r ? cur_wd   : nxt_wd;
  assign b_re   = sel_r ? cur_re   : 1'b0;
  assign cur_rd = sel_r ? b_rd     : a_rd;

  lcut_ram #(.WIDTH(1), .DEPTH(Depth)) u_bank_a (
    .clk   (clk),
    .we    (a_we),
    .re    (a_re),
    .addr  (a_addr),
    .wdata (a_wd),
    .rdata (a_rd)
  );

  lcut_ram #(.WIDTH(1), .DEPTH(Depth)) u_bank_b (
    .clk   (clk),
    .we    (b_we),
    .re    (b_re),
    .addr  (b_addr),
    .wdata (b_wd),
    .rdata (b_rd)
  );

  // Bank swap on commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else if (cmd.finish && type_r == REQ_COMMIT) begin
      sel_r <= ~sel_r;
    end
  end

  // Result of the item
  always_comb begin
    case (type_r)
      REQ_WRITE:  res = val_r;
      REQ_UPDATE: res = live;
      REQ_READ:   res = cur_rd;
      default:    res = 1'b0;
    endcase
    if (oor || type_r == REQ_COMMIT) res = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) out_state_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-1){1'b0}}, out_state_r};

  // Status
  assign st.req       = type_r;
  assign st.oor       = oor;
  assign st.div_last  = dcnt_r == 4'(IDX_W - 1);
  assign st.step_last = step_r == LAST_STEP;
  assign st.clr_last  = clr_r == AddrW'(Depth - 1);
  assign st.out_free  = !out_valid_r || out_tready;

  // Neighbour sum of at most eight reads
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 4'd8)
    else $error("neighbour count overflow");

  // Every neighbour address lies inside the grid in use
  a_nbr_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.nbr_issue |-> (nbr_lin < total))
    else $error("neighbour address outside grid");

  // A result never overwrites one that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_tready))
    else $error("result register overwritten");

endmodule

`default_nettype wire

### rtl/core/life_cell_update_torus_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Toroidal B3/S23 cell grid with two one-bit banks, one current and one next.
// After reset the block clears bank a and takes no item meanwhile; configuration
// writes are taken at any time. One item is in work at a time and each gives
// one result, held in an output register so that the next item may be taken
// while it waits. A write, a commit or an item whose index lies outside the
// grid goes straight to its result, and a read first reads the addressed
// cell. An update splits the index into row and column with a bit-serial
// divider, forms the wrapped window, then makes nine reads of the single-port
// bank, one per cycle, and a final write of the new state to the next bank.
// num_rows and num_cols of zero act as 1, larger values saturate at
// MAX_ROWS / MAX_COLS; after a commit, cells of the new current bank that no
// update wrote hold stale or undefined values.
module life_cell_update_torus_core #(
  parameter int MAX_ROWS = lcut_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = lcut_pkg::DEF_MAX_COLS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [lcut_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [lcut_pkg::SIZE_W-1:0]         cfg_wdata,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // cell_index [11:0], cell_value [12], zero [15:13]
  input  wire logic [lcut_pkg::IN_DATA_W-1:0]      in_tdata,
  // req_type [1:0]
  input  wire logic [lcut_pkg::REQ_W-1:0]          in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // cell_state [0], zero [7:1]
  output logic      [lcut_pkg::OUT_DATA_W-1:0]     out_tdata
);

  import lcut_pkg::*;

  cmd_t    cmd;
  status_t st;

  lcut_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  lcut_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire
